>>> hdl/hof_pkg.sv
// Shared types and constants for the Hampel outlier filter.
package hof_pkg;

  localparam int WINDOW_DEF = 11;
  localparam int DATA_W     = 16;
  localparam int WORK_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * DATA_W;

  localparam logic [DATA_W-1:0] SCALE_RESET = 16'd1139;

  typedef logic signed [WORK_W-1:0] work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MED,
    ST_DEV,
    ST_MUL,
    ST_EMIT,
    ST_FLUSH
  } state_t;

endpackage

>>> hdl/hof_rank_unit.sv
// Rank test: is the head entry of the work array the median of the array.
module hof_rank_unit import hof_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  work_t work_i [2*(WINDOW/2)+1],
  output logic  is_med_o
);

  localparam int HALF  = WINDOW / 2;
  localparam int SPAN  = 2 * HALF + 1;
  localparam int CNT_W = $clog2(SPAN + 1);

  logic [CNT_W-1:0] lt_cnt;
  logic [CNT_W-1:0] le_cnt;

  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < SPAN; j++) begin
      if (work_i[j] < work_i[0]) begin
        lt_cnt = lt_cnt + CNT_W'(1);
      end
      if (work_i[j] <= work_i[0]) begin
        le_cnt = le_cnt + CNT_W'(1);
      end
    end
  end

  // median: at most HALF strictly below, more than HALF at or below
  assign is_med_o = (lt_cnt <= CNT_W'(HALF)) && (le_cnt > CNT_W'(HALF));

endmodule

>>> hdl/hampel_outlier_filter_top.sv
// Hampel outlier filter top level: window store, median/MAD sequencer, output register.
// A sample with a full window gets two rank passes over the shared rank unit: median, then MAD.
// No new sample is taken until the word for the last one is loaded; while the window fills,
//   the rank passes are skipped. At end of stream the window is rotated and the tail words
//   are flushed from its head; output stalls hold the flush.
// Reset (rst_n low, synchronous): idle, empty sequence, no word pending, scale 1139.
module hampel_outlier_filter_top import hof_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [DATA_W-1:0]        cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_sample,
  input  logic                     in_end_of_stream,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_filtered,
  output logic                     out_replaced,
  output logic                     out_last_out
);

  localparam int HALF  = WINDOW / 2;
  localparam int SPAN  = 2 * HALF + 1;
  localparam int IDX_W = $clog2(SPAN);

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] window_r [SPAN];
  work_t                    work_r   [SPAN];

  logic [DATA_W-1:0]        scale_r;
  logic [IDX_W-1:0]         seen_r;
  logic                     eos_r;
  logic                     full_r;
  logic [IDX_W-1:0]         first_r;
  logic [IDX_W-1:0]         cnt_r;
  logic                     phase_r;
  logic signed [DATA_W-1:0] med_r;
  logic [DATA_W-1:0]        mad_r;
  logic [PROD_W-1:0]        prod_r;
  logic [DATA_W-1:0]        dx_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_filtered_r;
  logic                     out_replaced_r;
  logic                     out_last_r;

  logic                     accept;
  logic                     slot_free;
  logic                     seen_full;
  logic                     seen_cen;
  logic [IDX_W-1:0]         first_nxt;
  logic                     is_med;
  logic                     med_last;
  logic                     outlier;
  logic                     out_load;
  logic signed [DATA_W-1:0] out_val;
  logic                     out_rep;
  logic                     out_lst;
  logic                     flush_rot;
  logic                     flush_emit;

  function automatic logic [DATA_W-1:0] abs_diff(input logic signed [DATA_W-1:0] a,
                                                 input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    if (d < 0) begin
      d = -d;
    end
    return d[DATA_W-1:0];
  endfunction

  hof_rank_unit #(.WINDOW(WINDOW)) u_rank (
    .work_i   (work_r),
    .is_med_o (is_med)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign seen_full = (seen_r == IDX_W'(2 * HALF));
  assign seen_cen  = (seen_r >= IDX_W'(HALF));
  assign first_nxt = seen_cen ? IDX_W'(HALF + 1) : (IDX_W'(SPAN - 1) - seen_r);
  assign med_last  = (cnt_r == IDX_W'(SPAN - 1));
  assign outlier   = full_r && ({8'h00, dx_r, 8'h00} > prod_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (seen_full)        state_nxt = ST_LOAD;
          else if (seen_cen)             state_nxt = ST_EMIT;
          else if (in_end_of_stream)     state_nxt = ST_FLUSH;
          else                           state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: state_nxt = ST_MED;
      ST_MED: begin
        if (med_last) begin
          state_nxt = phase_r ? ST_MUL : ST_DEV;
        end
      end
      ST_DEV: state_nxt = ST_MED;
      ST_MUL: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = eos_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (flush_emit && med_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    out_load   = 1'b0;
    out_val    = window_r[HALF];
    out_rep    = 1'b0;
    out_lst    = 1'b0;
    flush_rot  = 1'b0;
    flush_emit = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EMIT: begin
        out_load = slot_free;
        out_rep  = outlier;
        out_val  = outlier ? med_r : window_r[HALF];
      end
      ST_FLUSH: begin
        // rotate the wanted entry round to the head, then hand out one per word
        flush_emit = (cnt_r >= first_r) && slot_free;
        flush_rot  = (cnt_r < first_r) || flush_emit;
        out_load   = flush_emit;
        out_val    = window_r[0];
        out_lst    = med_last;
      end
      ST_LOAD, ST_MED, ST_DEV, ST_MUL: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      scale_r     <= SCALE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_end_of_stream) begin
          seen_r <= '0;
        end else if (!seen_full) begin
          seen_r <= seen_r + IDX_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < SPAN - 1; i++) begin
        window_r[i] <= window_r[i + 1];
      end
      window_r[SPAN-1] <= in_sample;
      eos_r            <= in_end_of_stream;
      full_r           <= seen_full;
      first_r          <= first_nxt;
      cnt_r            <= '0;
    end else if (flush_rot) begin
      for (int i = 0; i < SPAN - 1; i++) begin
        window_r[i] <= window_r[i + 1];
      end
      window_r[SPAN-1] <= window_r[0];
      cnt_r            <= cnt_r + IDX_W'(1);
    end

    unique case (state_r)
      ST_LOAD: begin
        for (int j = 0; j < SPAN; j++) begin
          work_r[j] <= $signed({window_r[j][DATA_W-1], window_r[j]});
        end
        phase_r <= 1'b0;
        cnt_r   <= '0;
      end
      ST_MED: begin
        for (int j = 0; j < SPAN - 1; j++) begin
          work_r[j] <= work_r[j + 1];
        end
        work_r[SPAN-1] <= work_r[0];
        if (is_med) begin
          if (phase_r) begin
            mad_r <= work_r[0][DATA_W-1:0];
          end else begin
            med_r <= work_r[0][DATA_W-1:0];
          end
        end
        cnt_r <= cnt_r + IDX_W'(1);
      end
      ST_DEV: begin
        // deviations are non-negative, so the signed rank compare still holds
        for (int j = 0; j < SPAN; j++) begin
          work_r[j] <= $signed({1'b0, abs_diff(window_r[j], med_r)});
        end
        phase_r <= 1'b1;
        cnt_r   <= '0;
      end
      ST_MUL: begin
        prod_r <= scale_r * mad_r;
        dx_r   <= abs_diff(window_r[HALF], med_r);
        // tail flush counts from the head again
        cnt_r  <= '0;
      end
      ST_IDLE, ST_EMIT, ST_FLUSH: begin
        phase_r <= phase_r;
      end
      default: phase_r <= phase_r;
    endcase

    if (out_load) begin
      out_filtered_r <= out_val;
      out_replaced_r <= out_rep;
      out_last_r     <= out_lst;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_replaced = out_replaced_r;
  assign out_last_out = out_last_r;

endmodule

>>> hdl/hof_checker.sv
// Port-level checks for the Hampel outlier filter, bound to the top level.
module hof_checker import hof_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_filtered,
  input logic                     out_replaced,
  input logic                     out_last_out
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered)
      && $stable(out_replaced) && $stable(out_last_out))
    else $error("output word changed while stalled");

  // the last word of a stream is never replaced
  a_last_not_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_out |-> !out_replaced)
    else $error("final word flagged as replaced");

  // a fresh word only appears while the sequencer is busy
  a_word_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("word issued while input side was idle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("word pending after reset");

endmodule

bind hampel_outlier_filter_top hof_checker u_hof_checker (.*);

>>> tb/hampel_outlier_filter_top_tb.sv
// Self-checking testbench for the Hampel outlier filter: directed cases, random streams, stalls.
`timescale 1ns / 1ps

module hampel_outlier_filter_top_tb;
  import hof_pkg::*;

  localparam int WINDOW        = WINDOW_DEF;
  localparam int HALF          = WINDOW / 2;
  localparam int SPAN          = 2 * HALF + 1;
  localparam int SETTLE_CYCLES = 4 * SPAN + 24;
  localparam int LONG_HOLD     = 400;

  typedef int span_arr_t [SPAN];

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered;
    logic                     replaced;
    logic                     last_out;
  } filt_word_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     cfg_wr_en        = 1'b0;
  logic [DATA_W-1:0]        cfg_wr_data      = '0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_sample        = '0;
  logic                     in_end_of_stream = 1'b0;
  logic                     out_valid;
  logic                     out_ready        = 1'b0;
  logic signed [DATA_W-1:0] out_filtered;
  logic                     out_replaced;
  logic                     out_last_out;

  // predictor state
  span_arr_t         win_hist  = '{default: 0};
  int                seq_len   = 0;
  logic [DATA_W-1:0] thr_scale = SCALE_RESET;
  filt_word_t        expected_words[$];

  int       fail_count   = 0;
  int       burst_left   = 0;
  bit       hold_request = 1'b0;
  int       hold_left    = 0;
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  filt_word_t want;

  hampel_outlier_filter_top #(.WINDOW(WINDOW)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered     (out_filtered),
    .out_replaced     (out_replaced),
    .out_last_out     (out_last_out)
  );

  always #5 clk = ~clk;

  function automatic int span_median(input span_arr_t vals);
    span_arr_t tmp;
    int v, j;
    tmp = vals;
    for (int i = 1; i < SPAN; i++) begin
      v = tmp[i];
      j = i - 1;
      while (j >= 0 && tmp[j] > v) begin
        tmp[j + 1] = tmp[j];
        j--;
      end
      tmp[j + 1] = v;
    end
    return tmp[HALF];
  endfunction

  function automatic void queue_word(input filt_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  // Shift the sample in, then queue the centred word and any tail flush.
  function automatic void hampel_predict(input logic signed [DATA_W-1:0] s, input logic eos);
    span_arr_t  dev;
    int         c, x, med, mad, dx, first;
    filt_word_t w;
    c = seq_len;
    for (int i = 0; i < SPAN - 1; i++) win_hist[i] = win_hist[i + 1];
    win_hist[SPAN - 1] = int'(s);
    if (c >= HALF) begin
      x = win_hist[SPAN - 1 - HALF];
      w.filtered = x[DATA_W-1:0];
      w.replaced = 1'b0;
      w.last_out = 1'b0;
      if (c >= 2 * HALF) begin
        med = span_median(win_hist);
        for (int i = 0; i < SPAN; i++)
          dev[i] = (win_hist[i] >= med) ? win_hist[i] - med : med - win_hist[i];
        mad = span_median(dev);
        dx  = (x >= med) ? x - med : med - x;
        if (longint'(dx) * 256 > longint'(thr_scale) * longint'(mad)) begin
          w.filtered = med[DATA_W-1:0];
          w.replaced = 1'b1;
        end
      end
      queue_word(w);
    end
    if (eos) begin
      first = (c >= HALF) ? SPAN - HALF : SPAN - 1 - c;
      for (int i = first; i < SPAN; i++) begin
        w.filtered = win_hist[i][DATA_W-1:0];
        w.replaced = 1'b0;
        w.last_out = (i == SPAN - 1);
        queue_word(w);
      end
      seq_len = 0;
    end else begin
      seq_len = (c < 2 * HALF) ? c + 1 : c;
    end
  endfunction

  // Offer one word, wait for it to be taken, then keep to the burst/gap pattern.
  task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic eos);
    int gap;
    in_valid         <= 1'b1;
    in_sample        <= s;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    hampel_predict(s, eos);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sequences without a word due may leave the block busy, hence the settle time.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [DATA_W-1:0] value);
    drain_and_settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_scale = value;
  endtask

  // Mostly a noisy level with occasional spikes; some full-range and flat streams.
  task automatic send_random_sequence(input int len);
    int style, base, amp, v;
    style = $urandom_range(0, 9);
    base  = int'($urandom_range(0, 40000)) - 20000;
    amp   = $urandom_range(0, 300);
    for (int k = 0; k < len; k++) begin
      if (style < 2)
        v = int'($urandom_range(0, 65535)) - 32768;
      else if (style == 2)
        v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768 : base;
      else if ($urandom_range(0, 7) == 0)
        v = int'($urandom_range(0, 65535)) - 32768;
      else
        v = base + int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_sample(v[DATA_W-1:0], k == len - 1);
    end
  endtask

  task automatic run_random_items(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, SPAN - 1)
                                        : $urandom_range(SPAN, 3 * SPAN);
      send_random_sequence(len);
      sent += len;
    end
  endtask

  // Sequences shorter than the span pass straight through at end of stream.
  task automatic test_short_sequences();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
  endtask

  // Flat window with two spikes: MAD is zero, both spikes get replaced.
  task automatic test_zero_deviation();
    for (int k = 0; k < SPAN + 2; k++) begin
      if (k == HALF)
        send_sample(16'sh8000, 1'b0);
      else if (k == HALF + 2)
        send_sample(16'sh7FFF, 1'b0);
      else
        send_sample(16'sd100, k == SPAN + 1);
    end
  endtask

  task automatic test_scale_extremes();
    write_scale(16'd0);
    run_random_items(70);
    write_scale(16'hFFFF);
    run_random_items(70);
  endtask

  task automatic test_random_scales();
    write_scale(SCALE_RESET);
    run_random_items(70);
    write_scale(16'd256);
    run_random_items(60);
    write_scale(16'($urandom_range(0, 65535)));
    run_random_items(70);
  endtask

  // Receiver holds off for a long stretch while samples keep being offered.
  task automatic test_backpressure();
    write_scale(16'($urandom_range(512, 4096)));
    hold_request = 1'b1;
    send_random_sequence(3 * SPAN);
  endtask

  // Result checking and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: filtered %0d replaced %0b last_out %0b",
               out_filtered, out_replaced, out_last_out);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_filtered !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered, out_filtered);
          fail_count++;
        end
        if (out_replaced !== want.replaced) begin
          $error("replaced: expected %0b, got %0b", want.replaced, out_replaced);
          fail_count++;
        end
        if (out_last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, out_last_out);
          fail_count++;
        end
      end
    end

    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_sequences();
    test_zero_deviation();
    test_scale_extremes();
    test_random_scales();
    test_backpressure();
    drain_and_settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
hdl/hof_pkg.sv
hdl/hof_rank_unit.sv
hdl/hampel_outlier_filter_top.sv
hdl/hof_checker.sv
tb/hampel_outlier_filter_top_tb.sv
